FILE: hw/rtl/rpa_pkg.sv
package rpa_pkg;

  // Fixed field widths of the request and result items
  localparam int FUNC_W   = 2;
  localparam int PAGE_W   = 12;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 13;

  localparam int NUM_PAGES_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 8;

  // Request kinds
  localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_ADDREF = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    RS_ALLOCATED = 3'd0,
    RS_OOM       = 3'd1,
    RS_RETURNED  = 3'd2,
    RS_SHARED    = 3'd3,
    RS_ERROR     = 3'd4,
    RS_ADDED     = 3'd5,
    RS_SATURATED = 3'd6
  } status_t;

  // Commands from the controller to the free stack
  typedef struct packed {
    logic rd;    // read top entry (data next cycle)
    logic pop;   // commit a pop
    logic push;  // push page
  } stk_cmd_t;

endpackage

FILE: hw/rtl/rpa_ram.sv
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/rpa_free_stack.sv
module rpa_free_stack
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int IDX_W     = $clog2(NUM_PAGES),
  parameter int DEPTH_W   = $clog2(NUM_PAGES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stk_cmd_t           cmd,
  input  logic [IDX_W-1:0]   push_page,
  output logic [IDX_W-1:0]   top_page,
  output logic [DEPTH_W-1:0] depth
);

  logic [DEPTH_W-1:0] depth_r;
  // Lowest depth ever reached; entries below it are unwritten: page = index
  logic [DEPTH_W-1:0] lwm_r;
  logic [DEPTH_W-1:0] top_addr;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               byp_r;
  logic [IDX_W-1:0]   ram_rdata;
  logic               push_ok;

  assign top_addr = depth_r - DEPTH_W'(1);
  assign push_ok  = cmd.push && (int'(depth_r) < NUM_PAGES);

  rpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_PAGES),
    .AW    (IDX_W)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (depth_r[IDX_W-1:0]),
    .wr_data (push_page),
    .rd_en   (cmd.rd),
    .rd_addr (top_addr[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_W'(NUM_PAGES);
      lwm_r   <= DEPTH_W'(NUM_PAGES);
    end else begin
      if (cmd.pop) begin
        depth_r <= top_addr;
        if (top_addr < lwm_r) begin
          lwm_r <= top_addr;
        end
      end else if (push_ok) begin
        depth_r <= depth_r + DEPTH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_idx_r <= top_addr[IDX_W-1:0];
      byp_r    <= (top_addr < lwm_r);
    end
  end

  assign top_page = byp_r ? rd_idx_r : ram_rdata;
  assign depth    = depth_r;

  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (depth_r == $past(depth_r) || depth_r == $past(depth_r) + DEPTH_W'(1)
                      || depth_r + DEPTH_W'(1) == $past(depth_r)))
    else $error("free stack depth jumped by more than one");

  a_lwm_below_depth: assert property (@(posedge clk) disable iff (!rst_n)
    lwm_r <= depth_r)
    else $error("low-water mark above stack depth");

endmodule

FILE: hw/rtl/refcounted_page_allocator.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   in_func, in_page_number
// out_      output     out_valid / out_stall out_page_out, out_status, out_free_count
//
// Free, add-reference and rejected requests go from S_IDLE to S_CNT or S_RES; allocate
// goes via S_TOP: its count address comes from the stack read, so two dependent RAM reads.
// A result that is stalled holds the block in its write-back cycle until taken.
// After reset the count RAM is cleared one entry a cycle, with in_stall high throughout.
// Reset is synchronous, active low.
module refcounted_page_allocator
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [PAGE_W-1:0]   in_page_number,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PAGE_W-1:0]   out_page_out,
  output logic [STATUS_W-1:0] out_status,
  output logic [FREE_W-1:0]   out_free_count
);

  localparam int IDX_W   = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TOP,
    S_CNT,
    S_RES
  } state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    clr_r;
  logic [FUNC_W-1:0]   func_r;
  logic [IDX_W-1:0]    pg_r;
  logic [PAGE_W-1:0]   echo_r;
  status_t             res_status_r;
  logic                out_valid_r;
  logic [PAGE_W-1:0]   out_page_r;
  status_t             out_status_r;
  logic [FREE_W-1:0]   out_free_r;

  logic                acc;
  logic                slot_free;
  logic                commit;
  logic                range_ok;
  logic [IDX_W-1:0]    in_idx;
  stk_cmd_t            stk_cmd;
  logic [IDX_W-1:0]    top_page;
  logic [DEPTH_W-1:0]  depth;
  logic [DEPTH_W-1:0]  depth_after;
  logic                cnt_rd_en;
  logic [IDX_W-1:0]    cnt_rd_addr;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                cnt_wr_en;
  logic [IDX_W-1:0]    cnt_wr_addr;
  logic [COUNT_BITS-1:0] cnt_wr_data;
  logic [COUNT_BITS-1:0] cnt_new;
  status_t             cnt_status;

  assign acc       = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign commit    = (state_r == S_CNT) && slot_free;
  assign range_ok  = int'(in_page_number) < NUM_PAGES;
  assign in_idx    = IDX_W'(in_page_number);

  // Count update for the request being committed
  always_comb begin
    cnt_new    = cnt_rdata;
    cnt_status = RS_ERROR;
    unique case (func_r)
      FN_ALLOC, FN_ADDREF: begin
        if (cnt_rdata == CMAX) begin
          cnt_status = RS_SATURATED;
        end else begin
          cnt_new    = cnt_rdata + COUNT_BITS'(1);
          cnt_status = (func_r == FN_ALLOC) ? RS_ALLOCATED : RS_ADDED;
        end
      end
      FN_FREE: begin
        if (cnt_rdata == '0) begin
          cnt_status = RS_ERROR;
        end else begin
          cnt_new    = cnt_rdata - COUNT_BITS'(1);
          cnt_status = (cnt_new == '0) ? RS_RETURNED : RS_SHARED;
        end
      end
      default: begin
        cnt_status = RS_ERROR;
      end
    endcase
  end

  always_comb begin
    depth_after = depth;
    if (func_r == FN_ALLOC) begin
      depth_after = depth - DEPTH_W'(1);
    end else if (cnt_status == RS_RETURNED && int'(depth) < NUM_PAGES) begin
      depth_after = depth + DEPTH_W'(1);
    end
  end

  assign stk_cmd.rd   = acc && (in_func == FN_ALLOC) && (depth != '0);
  assign stk_cmd.pop  = commit && (func_r == FN_ALLOC);
  assign stk_cmd.push = commit && (func_r == FN_FREE) && (cnt_status == RS_RETURNED);

  rpa_free_stack #(
    .NUM_PAGES (NUM_PAGES),
    .IDX_W     (IDX_W),
    .DEPTH_W   (DEPTH_W)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stk_cmd),
    .push_page (pg_r),
    .top_page  (top_page),
    .depth     (depth)
  );

  assign cnt_rd_en   = (state_r == S_TOP) ||
                       (acc && range_ok && (in_func == FN_FREE || in_func == FN_ADDREF));
  assign cnt_rd_addr = (state_r == S_TOP) ? top_page : in_idx;
  assign cnt_wr_en   = (state_r == S_CLEAR) || commit;
  assign cnt_wr_addr = (state_r == S_CLEAR) ? clr_r : pg_r;
  assign cnt_wr_data = (state_r == S_CLEAR) ? '0 : cnt_new;

  rpa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES),
    .AW    (IDX_W)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (cnt_rd_en),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a result loaded this cycle takes precedence over the drain
      if (out_valid_r && !out_stall && state_r != S_CNT && state_r != S_RES) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IDX_W'(1);
          if (clr_r == IDX_W'(NUM_PAGES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            func_r <= in_func;
            pg_r   <= in_idx;
            echo_r <= (in_func == FN_ALLOC) ? '0 : in_page_number;
            if (in_func == FN_ALLOC) begin
              if (depth == '0) begin
                res_status_r <= RS_OOM;
                state_r      <= S_RES;
              end else begin
                state_r <= S_TOP;
              end
            end else if (range_ok && (in_func == FN_FREE || in_func == FN_ADDREF)) begin
              state_r <= S_CNT;
            end else begin
              res_status_r <= RS_ERROR;
              state_r      <= S_RES;
            end
          end
        end
        S_TOP: begin
          pg_r    <= top_page;
          state_r <= S_CNT;
        end
        S_CNT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_page_r   <= PAGE_W'(pg_r);
            out_status_r <= cnt_status;
            out_free_r   <= FREE_W'(depth_after);
            state_r      <= S_IDLE;
          end
        end
        S_RES: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_page_r   <= echo_r;
            out_status_r <= res_status_r;
            out_free_r   <= FREE_W'(depth);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_page_out   = out_page_r;
  assign out_status     = out_status_r;
  assign out_free_count = out_free_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> in_stall)
    else $error("request accepted but block not busy next cycle");

  a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && func_r == FN_ALLOC) |-> (depth != '0))
    else $error("allocation committed on an empty free stack");

  a_no_push_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(stk_cmd.push && stk_cmd.pop) && !(stk_cmd.rd && commit))
    else $error("conflicting free stack commands");

  a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> int'(out_free_r) <= NUM_PAGES)
    else $error("free count above pool size");

endmodule
